### rtl/core/mavt_pkg.sv
// Package for the multi-turn angle and velocity tracker.
// Holds the widths, register codes, transfer and job types shared by all core files.
// No dependencies.
package mavt_pkg;

    localparam int ANGLE_BITS_DEF = 12;
    localparam int TURN_BITS_DEF  = 32;
    localparam int ANGLE_BITS_MAX = 16;
    localparam int TURN_BITS_MAX  = 32;

    localparam int RAW_W  = 12;
    localparam int TICK_W = 32;
    localparam int POS_W  = 44;
    localparam int VEL_W  = 32;
    localparam int THR_W  = 12;
    localparam int TPS_W  = 20;
    localparam int DATA_W = 32;

    localparam int MAG_W    = ANGLE_BITS_MAX + TURN_BITS_MAX;
    localparam int MAG_LO_W = MAG_W / 2;
    localparam int MAG_HI_W = MAG_W - MAG_LO_W;
    localparam int PROD_W   = MAG_W + TPS_W;

    localparam int QDEPTH     = 2;
    localparam int CFG_ADDR_W = 3;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(3276);
    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_VEL_READ = 1'b1;

    localparam logic REG_WRAP_THRESHOLD   = 1'b0;
    localparam logic REG_TICKS_PER_SECOND = 1'b1;

    typedef struct packed {
        logic             op;
        logic [RAW_W-1:0] raw_angle;
        logic [TICK_W-1:0] tick;
    } sample_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [VEL_W-1:0] velocity;
        logic                    velocity_valid;
    } result_t;

    typedef struct packed {
        logic              is_vel;
        logic [POS_W-1:0]  position;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [TICK_W-1:0] dt;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### rtl/core/mavt_front.sv
// Front end: accepts sample transfers, unwraps turns, keeps the velocity snapshot
// and pushes one classified job per transfer into the queue. Uses mavt_pkg.
module mavt_front
    import mavt_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int TURN_BITS  = TURN_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  sample_t          sample,
    input  logic [THR_W-1:0] wrap_threshold,
    input  q_stat_t          q_stat,
    output logic             push,
    output job_t             push_job
);

    localparam int DW = TURN_BITS + ANGLE_BITS + 1;

    logic                  primed_reg,     primed_next;
    logic [ANGLE_BITS-1:0] last_angle_reg, last_angle_next;
    logic [TURN_BITS-1:0]  turns_reg,      turns_next;
    logic [TICK_W-1:0]     last_tick_reg,  last_tick_next;
    logic [ANGLE_BITS-1:0] snap_angle_reg, snap_angle_next;
    logic [TURN_BITS-1:0]  snap_turns_reg, snap_turns_next;
    logic [TICK_W-1:0]     snap_tick_reg,  snap_tick_next;

    logic [ANGLE_BITS_MAX-1:0] raw_ext;
    logic [ANGLE_BITS-1:0]     ang;
    logic [ANGLE_BITS:0]       adiff;
    logic [ANGLE_BITS:0]       amag;
    logic [ANGLE_BITS_MAX:0]   amag_ext;
    logic [ANGLE_BITS_MAX:0]   thr_ext;
    logic                      wrap;
    logic [TURN_BITS-1:0]      turns_upd;

    logic [TURN_BITS-1:0]  dturn;
    logic [ANGLE_BITS:0]   dang;
    logic [DW-1:0]         dsum;
    logic [DW-1:0]         dabs;
    logic [TICK_W-1:0]     dt_raw;

    logic                  is_vel;
    logic [TURN_BITS-1:0]  pos_turns;
    logic [ANGLE_BITS-1:0] pos_angle;
    logic [63:0]           pos_wide;

    assign sample_ready = !q_stat.full;
    assign push         = sample_valid && !q_stat.full;
    assign is_vel       = (sample.op == OP_VEL_READ);

    assign raw_ext  = ANGLE_BITS_MAX'(sample.raw_angle);
    assign ang      = raw_ext[ANGLE_BITS-1:0];
    assign adiff    = {1'b0, ang} - {1'b0, last_angle_reg};
    assign amag     = adiff[ANGLE_BITS] ? (~adiff + 1'b1) : adiff;
    assign amag_ext = (ANGLE_BITS_MAX+1)'(amag);
    assign thr_ext  = (ANGLE_BITS_MAX+1)'(wrap_threshold);
    assign wrap     = primed_reg && (amag_ext > thr_ext);
    assign turns_upd = !wrap ? turns_reg :
                       adiff[ANGLE_BITS] ? (turns_reg + 1'b1) : (turns_reg - 1'b1);

    assign dturn  = turns_reg - snap_turns_reg;
    assign dang   = {1'b0, last_angle_reg} - {1'b0, snap_angle_reg};
    assign dsum   = {dturn[TURN_BITS-1], dturn, {ANGLE_BITS{1'b0}}}
                  + {{TURN_BITS{dang[ANGLE_BITS]}}, dang};
    assign dabs   = dsum[DW-1] ? (~dsum + 1'b1) : dsum;
    assign dt_raw = last_tick_reg - snap_tick_reg;

    assign pos_turns = is_vel ? turns_reg : turns_upd;
    assign pos_angle = is_vel ? last_angle_reg : ang;
    assign pos_wide  = ({{(64-TURN_BITS){pos_turns[TURN_BITS-1]}}, pos_turns} << ANGLE_BITS)
                     | 64'(pos_angle);

    always_comb
    begin
        push_job.is_vel   = is_vel;
        push_job.position = pos_wide[POS_W-1:0];
        push_job.neg      = dsum[DW-1];
        push_job.mag      = MAG_W'(dabs[DW-2:0]);
        push_job.dt       = (dt_raw == '0) ? TICK_W'(1) : dt_raw;
    end

    always_comb
    begin
        primed_next     = primed_reg;
        last_angle_next = last_angle_reg;
        turns_next      = turns_reg;
        last_tick_next  = last_tick_reg;
        snap_angle_next = snap_angle_reg;
        snap_turns_next = snap_turns_reg;
        snap_tick_next  = snap_tick_reg;
        if (push)
        begin
            if (is_vel)
            begin
                snap_angle_next = last_angle_reg;
                snap_turns_next = turns_reg;
                snap_tick_next  = last_tick_reg;
            end
            else
            begin
                primed_next     = 1'b1;
                last_angle_next = ang;
                turns_next      = turns_upd;
                last_tick_next  = sample.tick;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg     <= 1'b0;
            last_angle_reg <= '0;
            turns_reg      <= '0;
            last_tick_reg  <= '0;
            snap_angle_reg <= '0;
            snap_turns_reg <= '0;
            snap_tick_reg  <= '0;
        end
        else
        begin
            primed_reg     <= primed_next;
            last_angle_reg <= last_angle_next;
            turns_reg      <= turns_next;
            last_tick_reg  <= last_tick_next;
            snap_angle_reg <= snap_angle_next;
            snap_turns_reg <= snap_turns_next;
            snap_tick_reg  <= snap_tick_next;
        end
    end

endmodule

### rtl/core/mavt_queue.sv
// Short job queue between the front and back ends of the tracker.
// Uses job_t and q_stat_t from mavt_pkg.
module mavt_queue
    import mavt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t q_stat
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    job_t              slots_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign head         = slots_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/mavt_back.sv
// Back end: drains the job queue, scales velocity jobs with a split multiplier and a
// bit-serial restoring divider, and holds the result register. Uses mavt_pkg.
module mavt_back
    import mavt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  q_stat_t          q_stat,
    input  job_t             head,
    output logic             pop,
    input  logic [TPS_W-1:0] ticks_per_second,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    localparam int CNT_W = $clog2(VEL_W);
    localparam int OVF_W = PROD_W - VEL_W;

    logic [2:0]                  state_reg,  state_next;
    job_t                        job_reg,    job_next;
    logic [MAG_LO_W+TPS_W-1:0]   pp_lo_reg,  pp_lo_next;
    logic [MAG_HI_W+TPS_W-1:0]   pp_hi_reg,  pp_hi_next;
    logic [PROD_W-1:0]           prod_reg,   prod_next;
    logic [TICK_W-1:0]           rem_reg,    rem_next;
    logic [VEL_W-1:0]            quo_reg,    quo_next;
    logic                        ovf_reg,    ovf_next;
    logic [CNT_W-1:0]            cnt_reg,    cnt_next;
    logic                        res_valid_reg, res_valid_next;
    result_t                     res_reg,    res_next;

    logic              out_free;
    logic              ovf;
    logic [TICK_W:0]   trial;
    logic [TICK_W:0]   trial_sub;
    logic              ge;
    logic              sat;
    logic [VEL_W-1:0]  vel_val;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign out_free     = !res_valid_reg || result_ready;

    assign ovf       = prod_reg[PROD_W-1:VEL_W] >= OVF_W'(job_reg.dt);
    assign trial     = {rem_reg, quo_reg[VEL_W-1]};
    assign trial_sub = trial - {1'b0, job_reg.dt};
    assign ge        = (trial >= {1'b0, job_reg.dt});
    assign sat       = ovf_reg || quo_reg[VEL_W-1];
    assign vel_val   = job_reg.neg ? (sat ? VEL_MIN : (~quo_reg + 1'b1))
                                   : (sat ? VEL_MAX : quo_reg);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        pp_lo_next     = pp_lo_reg;
        pp_hi_next     = pp_hi_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        ovf_next       = ovf_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        pop            = 1'b0;

        if (res_valid_reg && result_ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    pop = 1'b1;
                    if (head.is_vel)
                    begin
                        job_next   = head;
                        state_next = ST_MUL_LO;
                    end
                    else
                    begin
                        res_next.position       = head.position;
                        res_next.velocity       = '0;
                        res_next.velocity_valid = 1'b0;
                        res_valid_next          = 1'b1;
                    end
                end
            end
            ST_MUL_LO:
            begin
                pp_lo_next = job_reg.mag[MAG_LO_W-1:0] * ticks_per_second;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                pp_hi_next = job_reg.mag[MAG_W-1:MAG_LO_W] * ticks_per_second;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                prod_next  = PROD_W'(pp_lo_reg) + (PROD_W'(pp_hi_reg) << MAG_LO_W);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // quotient fits in VEL_W bits only when the upper dividend is below dt
                ovf_next   = ovf;
                rem_next   = prod_reg[VEL_W+TICK_W-1:VEL_W];
                quo_next   = prod_reg[VEL_W-1:0];
                cnt_next   = '0;
                state_next = ovf ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
                quo_next = {quo_reg[VEL_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VEL_W-1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    res_next.position       = job_reg.position;
                    res_next.velocity       = vel_val;
                    res_next.velocity_valid = 1'b1;
                    res_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        pp_lo_reg <= pp_lo_next;
        pp_hi_reg <= pp_hi_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        ovf_reg   <= ovf_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

### rtl/core/multiturn_angle_velocity_tracker_core.sv
// Top level of the multi-turn angle and velocity tracker: APB register file, front end,
// job queue and back end. Uses mavt_pkg, mavt_front, mavt_queue and mavt_back.
//
//  channel   | signals                                  | content
//  ----------+------------------------------------------+------------------------------
//  sample    | sample_valid, sample_ready, sample       | op, raw_angle, tick
//  result    | result_valid, result_ready, result       | position, velocity, valid flag
//  config    | psel, penable, pwrite, paddr, pwdata ... | wrap_threshold, ticks_per_second
//
// A sample transfer is queued; its result is registered when the back end pops it. A
// velocity read runs in the back end (two multiply halves, sum, range check, 32-step
// restoring divider), skipping the divider on overflow. The front keeps taking transfers
// while the queue has room. Reset clears all tracking state; no clearing pass is needed.
// A stalled result holds the back end, which then fills the queue and drops sample_ready.
module multiturn_angle_velocity_tracker_core
    import mavt_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int TURN_BITS  = TURN_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    logic [THR_W-1:0] thr_reg, thr_next;
    logic [TPS_W-1:0] tps_reg, tps_next;
    logic             cfg_wr;

    logic    push;
    job_t    push_job;
    logic    pop;
    job_t    head;
    q_stat_t q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        thr_next = thr_reg;
        tps_next = tps_reg;
        prdata   = '0;
        unique case (paddr[CFG_ADDR_W-1])
            REG_WRAP_THRESHOLD:
            begin
                prdata = DATA_W'(thr_reg);
                if (cfg_wr)
                    thr_next = pwdata[THR_W-1:0];
            end
            REG_TICKS_PER_SECOND:
            begin
                prdata = DATA_W'(tps_reg);
                if (cfg_wr)
                    tps_next = pwdata[TPS_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            tps_reg <= TPS_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
            tps_reg <= tps_next;
        end
    end

    mavt_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .TURN_BITS  (TURN_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample         (sample),
        .wrap_threshold (thr_reg),
        .q_stat         (q_stat),
        .push           (push),
        .push_job       (push_job)
    );

    mavt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    mavt_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_stat           (q_stat),
        .head             (head),
        .pop              (pop),
        .ticks_per_second (tps_reg),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .result           (result)
    );

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("job taken from an empty queue");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_sample_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.velocity_valid) |-> (result.velocity == '0))
        else $error("sample result carries a velocity");

    a_ready_follows_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && !q_stat.empty) |=> q_stat.full || !q_stat.empty)
        else $error("queue lost a job");

endmodule

### tb/multiturn_angle_velocity_tracker_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multiturn_angle_velocity_tracker_core: directed table, then
// random tracking phases under several register settings, checked against a local tracker.
// Depends on mavt_pkg and the RTL of the core.
module multiturn_angle_velocity_tracker_core_tb;
    import mavt_pkg::*;

    localparam int  PHASES       = 6;
    localparam int  PHASE_ITEMS  = 305;
    localparam int  DIR_ROWS     = 20;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  IDLE_LIMIT   = 3000;
    localparam int  ANGLE_COUNTS = 1 << ANGLE_BITS_DEF;
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef struct packed {
        logic             op;
        logic [RAW_W-1:0] raw_angle;
        logic [TICK_W-1:0] tick;
        logic             typed;
        result_t          res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    sample_t               sample_data = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // tracker state and register copies
    logic                      trk_primed = 1'b0;
    logic [ANGLE_BITS_DEF-1:0] trk_angle  = '0;
    logic [TURN_BITS_DEF-1:0]  trk_turns  = '0;
    logic [TICK_W-1:0]         trk_tick   = '0;
    logic [ANGLE_BITS_DEF-1:0] snap_angle = '0;
    logic [TURN_BITS_DEF-1:0]  snap_turns = '0;
    logic [TICK_W-1:0]         snap_tick  = '0;
    logic [THR_W-1:0]          cfg_thr    = THR_RESET;
    logic [TPS_W-1:0]          cfg_tps    = TPS_RESET;

    result_t  pending_results[$];
    int       mismatch_count = 0;
    int       hold_request = 0;
    bit       no_idle = 1'b0;
    int       motion_angle = 0;
    logic [TICK_W-1:0] motion_tick = '0;
    dir_row_t dir_tab [DIR_ROWS];

    multiturn_angle_velocity_tracker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t track_item(input sample_t s);
        result_t r;
        int      na;
        int      la;
        int      sa;
        int      diff;
        logic signed [TURN_BITS_DEF-1:0] dturn;
        longint  d;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned res;
        logic [TICK_W-1:0] dt;
        r = '0;
        if (s.op == OP_SAMPLE)
        begin
            na = s.raw_angle;
            la = trk_angle;
            diff = na - la;
            if (trk_primed && ((diff < 0 ? -diff : diff) > int'(cfg_thr)))
            begin
                if (diff > 0)
                    trk_turns = trk_turns - 1'b1;
                else
                    trk_turns = trk_turns + 1'b1;
            end
            trk_primed = 1'b1;
            trk_angle  = s.raw_angle;
            trk_tick   = s.tick;
            r.position = {trk_turns, trk_angle};
        end
        else
        begin
            la = trk_angle;
            sa = snap_angle;
            dturn = trk_turns - snap_turns;
            d = longint'(dturn) * ANGLE_COUNTS + (la - sa);
            dt = trk_tick - snap_tick;
            if (dt == 0)
                dt = 1;
            if (d < 0)
                mag = -d;
            else
                mag = d;
            q = mag / dt;
            rem = mag % dt;
            if (cfg_tps == 0)
                res = 0;
            else if (q > 64'hFFFF_FFFF)
                res = 64'd1 << 40;
            else
                res = q * cfg_tps + (rem * cfg_tps) / dt;
            if (d < 0)
                r.velocity = (res >= 64'h8000_0000) ? VEL_MIN : -res[VEL_W-1:0];
            else
                r.velocity = (res > 64'h7FFF_FFFF) ? VEL_MAX : res[VEL_W-1:0];
            r.velocity_valid = 1'b1;
            r.position = {trk_turns, trk_angle};
            snap_angle = trk_angle;
            snap_turns = trk_turns;
            snap_tick  = trk_tick;
        end
        return r;
    endfunction

    task automatic send_item(input sample_t s, input logic typed, input result_t typed_res);
        int      gap;
        result_t exp_res;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= s;
        do @(posedge clk); while (!sample_ready);
        exp_res = track_item(s);
        if (typed)
            exp_res = typed_res;
        pending_results.push_back(exp_res);
    endtask

    task automatic wait_results_done();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] kept;
        if (idx == REG_WRAP_THRESHOLD)
            kept = {{(DATA_W-THR_W){1'b0}}, val[THR_W-1:0]};
        else
            kept = {{(DATA_W-TPS_W){1'b0}}, val[TPS_W-1:0]};
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_WRAP_THRESHOLD)
            cfg_thr = val[THR_W-1:0];
        else
            cfg_tps = val[TPS_W-1:0];
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== kept)
        begin
            $error("prdata: expected %0d, got %0d", kept, prdata);
            mismatch_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int n_items);
        sample_t s;
        int      kind;
        int      step;
        int      nxt;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            s.op = OP_SAMPLE;
            if (kind < 20)
            begin
                s.op = OP_VEL_READ;
            end
            else if (kind < 80)
            begin
                step = int'($urandom_range(0, 1200)) - 600;
                motion_angle = (motion_angle + step) & (ANGLE_COUNTS - 1);
                motion_tick = motion_tick + $urandom_range(0, 40);
            end
            else if (kind < 90)
            begin
                // jumps right at the wrap threshold
                step = int'(cfg_thr) + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    step = -step;
                nxt = motion_angle + step;
                if (nxt < 0 || nxt >= ANGLE_COUNTS)
                    nxt = motion_angle - step;
                if (nxt < 0 || nxt >= ANGLE_COUNTS)
                    nxt = $urandom_range(0, ANGLE_COUNTS - 1);
                motion_angle = nxt;
                motion_tick = motion_tick + $urandom_range(0, 3);
            end
            else
            begin
                motion_angle = $urandom_range(0, ANGLE_COUNTS - 1);
                motion_tick = $urandom;
            end
            if (s.op == OP_SAMPLE)
            begin
                s.raw_angle = RAW_W'(motion_angle);
                s.tick      = motion_tick;
            end
            else
            begin
                s.raw_angle = RAW_W'($urandom);
                s.tick      = $urandom;
            end
            send_item(s, PRED, '0);
        end
    endtask

    initial
    begin
        int unsigned thr_val;
        int unsigned tps_val;
        sample_t     s;
        dir_tab[0]  = {OP_VEL_READ, 12'd0,    32'd0,         TYPED, 44'sd0,    32'sd0,     1'b1};
        dir_tab[1]  = {OP_SAMPLE,   12'd4095, 32'd100,       TYPED, 44'sd4095, 32'sd0,     1'b0};
        dir_tab[2]  = {OP_SAMPLE,   12'd0,    32'd200,       TYPED, 44'sd4096, 32'sd0,     1'b0};
        dir_tab[3]  = {OP_VEL_READ, 12'd0,    32'd0,         TYPED, 44'sd4096, 32'sd20480, 1'b1};
        dir_tab[4]  = {OP_SAMPLE,   12'd4095, 32'd200,       TYPED, 44'sd4095, 32'sd0,     1'b0};
        dir_tab[5]  = {OP_VEL_READ, 12'hFFF,  32'hFFFF_FFFF, TYPED, 44'sd4095, -32'sd1000, 1'b1};
        dir_tab[6]  = {OP_SAMPLE,   12'd819,  32'hFFFF_FFFF, TYPED, 44'sd819,  32'sd0,     1'b0};
        dir_tab[7]  = {OP_SAMPLE,   12'd4095, 32'd4,         TYPED, 44'sd4095, 32'sd0,     1'b0};
        dir_tab[8]  = {OP_SAMPLE,   12'd818,  32'd5,         PRED,  44'sd0,    32'sd0,     1'b0};
        dir_tab[9]  = {OP_VEL_READ, 12'd0,    32'd0,         PRED,  44'sd0,    32'sd0,     1'b0};
        dir_tab[10] = {OP_SAMPLE,   12'd0,    32'd6,         PRED,  44'sd0,    32'sd0,     1'b0};
        dir_tab[11] = {OP_SAMPLE,   12'd4095, 32'd7,         PRED,  44'sd0,    32'sd0,     1'b0};
        dir_tab[12] = {OP_SAMPLE,   12'd0,    32'd7,         PRED,  44'sd0,    32'sd0,     1'b0};
        dir_tab[13] = {OP_SAMPLE,   12'd4095, 32'd8,         PRED,  44'sd0,    32'sd0,     1'b0};
        dir_tab[14] = {OP_SAMPLE,   12'd2000, 32'd9,         PRED,  44'sd0,    32'sd0,     1'b0};
        dir_tab[15] = {OP_SAMPLE,   12'd0,    32'd10,        PRED,  44'sd0,    32'sd0,     1'b0};
        dir_tab[16] = {OP_SAMPLE,   12'd4095, 32'd11,        TYPED, -44'sd1,   32'sd0,     1'b0};
        dir_tab[17] = {OP_VEL_READ, 12'd0,    32'd0,         PRED,  44'sd0,    32'sd0,     1'b0};
        dir_tab[18] = {OP_VEL_READ, 12'hFFF,  32'hFFFF_FFFF, TYPED, -44'sd1,   32'sd0,     1'b1};
        dir_tab[19] = {OP_SAMPLE,   12'd4095, 32'd11,        TYPED, -44'sd1,   32'sd0,     1'b0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            s.op        = dir_tab[i].op;
            s.raw_angle = dir_tab[i].raw_angle;
            s.tick      = dir_tab[i].tick;
            send_item(s, dir_tab[i].typed, dir_tab[i].res);
        end
        wait_results_done();
        repeat (4) @(posedge clk);
        motion_angle = trk_angle;
        motion_tick  = trk_tick;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin thr_val = 3276; tps_val = 1000;     end
                1:       begin thr_val = 0;    tps_val = 1;        end
                2:       begin thr_val = 4095; tps_val = 20'hFFFFF; end
                3:       begin thr_val = 2047; tps_val = 0;        end
                4:       begin thr_val = $urandom_range(0, 4095); tps_val = 1000000; end
                default: begin
                    thr_val = $urandom_range(0, 4095);
                    tps_val = $urandom_range(1, 20'hFFFFF);
                end
            endcase
            // upper bits of the write data carry noise
            set_reg(REG_WRAP_THRESHOLD, ($urandom & 32'hFFFF_F000) | thr_val);
            set_reg(REG_TICKS_PER_SECOND, ($urandom & 32'hFFF0_0000) | tps_val);
            if (ph == 1)
                hold_request = HOLD_CYCLES;
            run_phase(PHASE_ITEMS / 2);
            if (ph == 2)
                wait_results_done();
            run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_results_done();
            repeat (4) @(posedge clk);
        end

        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int      stall;
        result_t exp_res;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing pending");
                mismatch_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (result_data.position !== exp_res.position)
                begin
                    $error("position: expected %0d, got %0d",
                           exp_res.position, result_data.position);
                    mismatch_count++;
                end
                if (result_data.velocity !== exp_res.velocity)
                begin
                    $error("velocity: expected %0d, got %0d",
                           exp_res.velocity, result_data.velocity);
                    mismatch_count++;
                end
                if (result_data.velocity_valid !== exp_res.velocity_valid)
                begin
                    $error("velocity_valid: expected %0d, got %0d",
                           exp_res.velocity_valid, result_data.velocity_valid);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && sample_ready) || (result_valid && result_ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/core/mavt_pkg.sv
rtl/core/mavt_front.sv
rtl/core/mavt_queue.sv
rtl/core/mavt_back.sv
rtl/core/multiturn_angle_velocity_tracker_core.sv
tb/multiturn_angle_velocity_tracker_core_tb.sv
